[hw/rtl/hrla_pkg.sv]
// Shared constants, types and helper functions for the hex ring LED animation block.
package hrla_pkg;

   localparam int ROWS           = 10;
   localparam int COLS           = 10;
   localparam int REVERSE_RADIUS = 5;

   localparam int MAX_RADIUS = (ROWS > REVERSE_RADIUS ? ROWS : REVERSE_RADIUS) - 1;
   localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
   localparam int POS_W      = 8;

   localparam int TIME_W      = 64;
   localparam int FRAME_SHIFT = 20;
   localparam int FPS_W       = 8;
   localparam int FPS_BIT_W   = $clog2(FPS_W);
   localparam int FPS_RESET   = 30;

   localparam int ROW_W      = 4;
   localparam int COL_W      = 5;
   localparam int LED_W      = 7;
   localparam int IDX_FULL_W = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int DIR_W      = 3;

   localparam logic [DIR_W-1:0] DIR_LAST = DIR_W'(5);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE,
      CSR_FPS,
      CSR_SCALE_LOCK
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_STAR,
      MODE_SPLASH,
      MODE_STAR_REV,
      MODE_SPLASH_REV
   } mode_type;

   typedef logic signed [POS_W-1:0] pos_type;

   typedef struct packed {
      logic              start;
      logic              reverse;
      logic [FPS_W-1:0]  fps;
      logic [TIME_W-1:0] press;
      logic [TIME_W-1:0] now;
   } frame_cmd_type;

   typedef struct packed {
      logic             done;
      logic             ok;
      logic [RAD_W-1:0] radius;
   } frame_res_type;

   typedef struct packed {
      logic             start;
      logic             splash;
      logic [RAD_W-1:0] radius;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } walk_cmd_type;

   function automatic logic is_reverse(input mode_type m);
      logic res;
      case (m) inside
         MODE_STAR_REV, MODE_SPLASH_REV: res = 1'b1;
         default:                        res = 1'b0;
      endcase
      return res;
   endfunction

   function automatic logic is_splash(input mode_type m);
      logic res;
      case (m) inside
         MODE_SPLASH, MODE_SPLASH_REV: res = 1'b1;
         default:                      res = 1'b0;
      endcase
      return res;
   endfunction

   // ring sides in walk order: E, NE, NW, W, SW, SE
   function automatic pos_type dir_row_step(input logic [DIR_W-1:0] dir,
                                            input logic [RAD_W-1:0] stride);
      pos_type s;
      pos_type res;
      s = pos_type'(stride);
      case (dir) inside
         DIR_W'(1), DIR_W'(2): res = -s;
         DIR_W'(4), DIR_W'(5): res = s;
         default:              res = '0;
      endcase
      return res;
   endfunction

   function automatic pos_type dir_col_step(input logic [DIR_W-1:0] dir,
                                            input logic [RAD_W-1:0] stride);
      pos_type s;
      pos_type res;
      s = pos_type'(stride);
      case (dir)
         DIR_W'(0): res = s <<< 1;
         DIR_W'(1): res = s;
         DIR_W'(2): res = -s;
         DIR_W'(3): res = -(s <<< 1);
         DIR_W'(4): res = -s;
         DIR_W'(5): res = s;
         default:   res = '0;
      endcase
      return res;
   endfunction

endpackage

[hw/rtl/hrla_req_if.sv]
// Key request channel interface.
interface hrla_req_if import hrla_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ROW_W-1:0]  center_row;
   logic [COL_W-1:0]  center_col;
   logic [TIME_W-1:0] press_time;
   logic [TIME_W-1:0] now_time;
   logic              is_command;
   logic              note_unused;
   logic              in_scale;

   modport source (output valid, center_row, center_col, press_time, now_time,
                   is_command, note_unused, in_scale, input ready);
   modport sink (input valid, center_row, center_col, press_time, now_time,
                 is_command, note_unused, in_scale, output ready);
   modport monitor (input valid, ready, center_row, center_col, press_time, now_time,
                    is_command, note_unused, in_scale);
endinterface

[hw/rtl/hrla_rsp_if.sv]
// LED result channel interface.
interface hrla_rsp_if import hrla_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [LED_W-1:0] led_index;
   logic             led_valid;
   logic             last;

   modport source (output valid, led_index, led_valid, last, input ready);
   modport sink (input valid, led_index, led_valid, last, output ready);
   modport monitor (input valid, ready, led_index, led_valid, last);
endinterface

[hw/rtl/hrla_csr_if.sv]
// Register write channel interface.
interface hrla_csr_if import hrla_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/hrla_frame_unit.sv]
// Frame number and ring radius: elapsed time times frame rate by shift-and-add.
module hrla_frame_unit import hrla_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  frame_cmd_type cmd,
   output frame_res_type res
);

   typedef enum logic [1:0] {F_IDLE, F_MUL, F_CHECK} fstate_type;

   fstate_type            state_ff;
   logic [TIME_W-1:0]     diff_ff;
   logic [TIME_W-1:0]     acc_ff;
   logic [TIME_W-1:0]     acc_in;
   logic [FPS_W-1:0]      fps_ff;
   logic [FPS_BIT_W-1:0]  bit_ff;
   logic                  rev_ff;
   frame_res_type         res_ff;
   logic [TIME_W-FRAME_SHIFT-1:0] quot;
   logic [RAD_W-1:0]      quot_lo;

   assign acc_in  = (acc_ff << 1) + (fps_ff[bit_ff] ? diff_ff : '0);
   assign quot    = acc_ff[TIME_W-1:FRAME_SHIFT];
   assign quot_lo = acc_ff[FRAME_SHIFT +: RAD_W];
   assign res     = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         res_ff.done <= 1'b0;
      end else begin
         res_ff.done <= 1'b0;
         unique case (state_ff)
            F_IDLE: begin
               if (cmd.start) begin
                  diff_ff  <= cmd.now - cmd.press;
                  acc_ff   <= '0;
                  fps_ff   <= cmd.fps;
                  rev_ff   <= cmd.reverse;
                  bit_ff   <= FPS_BIT_W'(FPS_W - 1);
                  state_ff <= F_MUL;
               end
            end
            F_MUL: begin
               acc_ff <= acc_in;
               if (bit_ff == '0) begin
                  state_ff <= F_CHECK;
               end else begin
                  bit_ff <= bit_ff - 1'b1;
               end
            end
            F_CHECK: begin
               res_ff.done <= 1'b1;
               if (rev_ff) begin
                  res_ff.ok     <= quot < (TIME_W-FRAME_SHIFT)'(REVERSE_RADIUS - 1);
                  res_ff.radius <= RAD_W'(REVERSE_RADIUS - 1) - quot_lo;
               end else begin
                  res_ff.ok     <= quot < (TIME_W-FRAME_SHIFT)'(ROWS - 1);
                  res_ff.radius <= quot_lo + RAD_W'(1);
               end
               state_ff <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

[hw/rtl/hrla_ring_walker.sv]
// Hex ring walker: steps around the ring and drives one LED word per cycle while the result channel is not stalled.
module hrla_ring_walker import hrla_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  walk_cmd_type cmd,
   output logic         done,
   hrla_rsp_if.source   rsp_bus
);

   typedef enum logic {W_IDLE, W_RUN} wstate_type;

   wstate_type            state_ff;
   pos_type               r_ff;
   pos_type               c_ff;
   logic [DIR_W-1:0]      dir_ff;
   logic [RAD_W-1:0]      step_ff;
   logic [RAD_W-1:0]      steps_ff;
   logic [RAD_W-1:0]      stride_ff;
   logic                  done_ff;
   logic                  valid_ff;
   logic [LED_W-1:0]      led_index_ff;
   logic                  led_valid_ff;
   logic                  last_ff;
   logic                  on_grid;
   logic [IDX_FULL_W-1:0] idx_full;
   logic                  side_end;
   logic                  ring_end;
   logic                  load;

   assign on_grid = (r_ff >= pos_type'(0)) && (r_ff < pos_type'(ROWS)) &&
                    (c_ff >= pos_type'(0)) && (c_ff < pos_type'(2 * COLS)) &&
                    !(r_ff[0] ^ c_ff[0]);
   assign idx_full = IDX_FULL_W'(COLS) * IDX_FULL_W'($unsigned(r_ff)) +
                     IDX_FULL_W'(c_ff[POS_W-1:1]);
   assign side_end = (step_ff + RAD_W'(1)) == steps_ff;
   assign ring_end = side_end && (dir_ff == DIR_LAST);
   assign load     = (state_ff == W_RUN) && (!valid_ff || rsp_bus.ready);

   assign done              = done_ff;
   assign rsp_bus.valid     = valid_ff;
   assign rsp_bus.led_index = led_index_ff;
   assign rsp_bus.led_valid = led_valid_ff;
   assign rsp_bus.last      = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (valid_ff && rsp_bus.ready) begin
            valid_ff <= 1'b0;
         end
         unique case (state_ff)
            W_IDLE: begin
               if (cmd.start) begin
                  r_ff      <= pos_type'(cmd.row) + pos_type'(cmd.radius);
                  c_ff      <= pos_type'(cmd.col) - pos_type'(cmd.radius);
                  dir_ff    <= '0;
                  step_ff   <= '0;
                  steps_ff  <= cmd.splash ? cmd.radius : RAD_W'(1);
                  stride_ff <= cmd.splash ? RAD_W'(1) : cmd.radius;
                  state_ff  <= W_RUN;
               end
            end
            W_RUN: begin
               if (load) begin
                  valid_ff     <= 1'b1;
                  led_valid_ff <= on_grid;
                  led_index_ff <= on_grid ? idx_full[LED_W-1:0] : '0;
                  last_ff      <= ring_end;
                  r_ff         <= r_ff + dir_row_step(dir_ff, stride_ff);
                  c_ff         <= c_ff + dir_col_step(dir_ff, stride_ff);
                  if (side_end) begin
                     step_ff <= '0;
                     dir_ff  <= dir_ff + 1'b1;
                  end else begin
                     step_ff <= step_ff + 1'b1;
                  end
                  if (ring_end) begin
                     done_ff  <= 1'b1;
                     state_ff <= W_IDLE;
                  end
               end
            end
            default: state_ff <= W_IDLE;
         endcase
      end
   end

endmodule

[hw/rtl/hex_ring_led_animation.sv]
// Top level: hex ring LED animation, one key word in, one LED word per ring position out.
// An animating key goes through the 8-step shift-and-add frame unit, then the ring walker,
// which gives one position per cycle unless stalled: 6*steps LED words (steps = radius
// in splash modes, else 1). No new key is taken until the ring is walked. An ineligible
// key is dropped in its accept cycle, one out of frame range at the frame check.
// Synchronous reset: mode star, 30 frames per second, scale lock off, both channels idle.
module hex_ring_led_animation import hrla_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   hrla_req_if.sink  req_bus,
   hrla_rsp_if.source rsp_bus,
   hrla_csr_if.sink  csr_bus
);

   typedef enum logic [1:0] {S_IDLE, S_FRAME, S_WALK} state_type;

   state_type        state_ff;
   mode_type         mode_ff;
   logic [FPS_W-1:0] fps_ff;
   logic             scale_lock_ff;
   logic [ROW_W-1:0] row_ff;
   logic [COL_W-1:0] col_ff;
   logic             req_take;
   logic             eligible;
   frame_cmd_type    frame_cmd;
   frame_res_type    frame_res;
   walk_cmd_type     walk_cmd;
   logic             walk_done;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign eligible      = (req_bus.press_time != '0) && !req_bus.is_command &&
                          !req_bus.note_unused && (!scale_lock_ff || req_bus.in_scale);

   assign frame_cmd.start   = req_take && eligible;
   assign frame_cmd.reverse = is_reverse(mode_ff);
   assign frame_cmd.fps     = fps_ff;
   assign frame_cmd.press   = req_bus.press_time;
   assign frame_cmd.now     = req_bus.now_time;

   assign walk_cmd.start  = (state_ff == S_FRAME) && frame_res.done && frame_res.ok;
   assign walk_cmd.splash = is_splash(mode_ff);
   assign walk_cmd.radius = frame_res.radius;
   assign walk_cmd.row    = row_ff;
   assign walk_cmd.col    = col_ff;

   hrla_frame_unit u_frame (
      .clock (clock),
      .reset (reset),
      .cmd   (frame_cmd),
      .res   (frame_res)
   );

   hrla_ring_walker u_walker (
      .clock   (clock),
      .reset   (reset),
      .cmd     (walk_cmd),
      .done    (walk_done),
      .rsp_bus (rsp_bus)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_STAR;
         fps_ff        <= FPS_W'(FPS_RESET);
         scale_lock_ff <= 1'b0;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            CSR_MODE:       mode_ff       <= mode_type'(csr_bus.data[1:0]);
            CSR_FPS:        fps_ff        <= csr_bus.data[FPS_W-1:0];
            CSR_SCALE_LOCK: scale_lock_ff <= csr_bus.data[0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (frame_cmd.start) begin
                  row_ff   <= req_bus.center_row;
                  col_ff   <= req_bus.center_col;
                  state_ff <= S_FRAME;
               end
            end
            S_FRAME: begin
               if (frame_res.done) begin
                  state_ff <= frame_res.ok ? S_WALK : S_IDLE;
               end
            end
            S_WALK: begin
               if (walk_done) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[hw/rtl/hrla_checker.sv]
// Port-level assertions for the hex ring LED animation block, bound to the top level.
module hrla_checker import hrla_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [TIME_W-1:0] req_press_time,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [LED_W-1:0]  rsp_led_index,
   input logic              rsp_led_valid,
   input logic              rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_led_index) &&
      $stable(rsp_led_valid) && $stable(rsp_last))
      else $error("result word changed while stalled");

   a_off_grid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_led_valid |-> rsp_led_index == '0)
      else $error("off-grid position with nonzero LED index");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

   a_unpressed_drop: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_press_time == '0 |=> req_ready)
      else $error("unpressed key word made the block busy");

endmodule

bind hex_ring_led_animation hrla_checker u_hrla_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .req_press_time (req_bus.press_time),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_led_index  (rsp_bus.led_index),
   .rsp_led_valid  (rsp_bus.led_valid),
   .rsp_last       (rsp_bus.last)
);

[tb/led_ring_checker.sv]
`timescale 1ns / 100ps
// Checker for the hex ring LED animation: tracks register writes, predicts ring words, compares.
module led_ring_checker import hrla_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   hrla_req_if.monitor req,
   hrla_rsp_if.monitor rsp,
   hrla_csr_if         csr,
   output int          failures,
   output int          pending,
   output int          checked
);

   typedef struct packed {
      logic [LED_W-1:0] led_index;
      logic             led_valid;
      logic             last;
   } led_word_type;

   localparam int MAX_REPORTS = 40;
   // ring sides in walk order: E, NE, NW, W, SW, SE
   localparam int SIDE_ROW_STEP [6] = '{0, -1, -1, 0, 1, 1};
   localparam int SIDE_COL_STEP [6] = '{2, 1, -1, -2, -1, 1};

   mode_type         mode_q;
   logic [FPS_W-1:0] fps_q;
   logic             lock_q;
   led_word_type     ring_words_q[$];

   function automatic bit on_grid(input int r, input int c);
      return r >= 0 && r < ROWS && c >= 0 && c < 2 * COLS && ((r + c) & 1) == 0;
   endfunction

   function automatic void predict_ring(input logic [ROW_W-1:0] row,
                                        input logic [COL_W-1:0] col,
                                        input logic [TIME_W-1:0] press,
                                        input logic [TIME_W-1:0] now,
                                        input logic cmd, input logic unused,
                                        input logic in_scale);
      logic [TIME_W-1:0] frame;
      int                radius;
      int                steps;
      int                stride;
      int                r;
      int                c;
      int                n;
      led_word_type      w;
      if (press == '0 || cmd || unused) return;
      if (lock_q && !in_scale) return;
      frame = 1 + (((now - press) * TIME_W'(fps_q)) >> FRAME_SHIFT);
      if (mode_q == MODE_STAR || mode_q == MODE_SPLASH) begin
         if (frame >= ROWS) return;
         radius = int'(frame);
      end else begin
         if (frame >= REVERSE_RADIUS) return;
         radius = REVERSE_RADIUS - int'(frame);
      end
      steps  = (mode_q == MODE_SPLASH || mode_q == MODE_SPLASH_REV) ? radius : 1;
      stride = radius / steps;
      r = int'(row) + radius;
      c = int'(col) - radius;
      n = 0;
      for (int d = 0; d < 6; d++) begin
         for (int s = 0; s < steps; s++) begin
            w.led_valid = on_grid(r, c);
            w.led_index = w.led_valid ? LED_W'(COLS * r + c / 2) : '0;
            n++;
            w.last = (n == 6 * steps);
            ring_words_q.push_back(w);
            r += SIDE_ROW_STEP[d] * stride;
            c += SIDE_COL_STEP[d] * stride;
         end
      end
   endfunction

   task automatic report_mismatch(input string what);
      failures++;
      if (failures <= MAX_REPORTS) $display("%0t ns: LED word mismatch: %s", $time, what);
   endtask

   always @(posedge clock) begin
      led_word_type want;
      if (reset) begin
         mode_q = MODE_STAR;
         fps_q  = FPS_W'(FPS_RESET);
         lock_q = 1'b0;
         ring_words_q.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CSR_MODE:       mode_q = mode_type'(csr.data[1:0]);
               CSR_FPS:        fps_q = csr.data[FPS_W-1:0];
               CSR_SCALE_LOCK: lock_q = csr.data[0];
               default:        ;
            endcase
         end
         // results first: a word at this edge never belongs to a key taken at this edge
         if (rsp.valid && rsp.ready) begin
            if (ring_words_q.size() == 0) begin
               report_mismatch("LED word arrived with none expected");
            end else begin
               want = ring_words_q.pop_front();
               checked++;
               if (rsp.led_index !== want.led_index)
                  report_mismatch($sformatf("led_index %0d, expected %0d",
                                            rsp.led_index, want.led_index));
               if (rsp.led_valid !== want.led_valid)
                  report_mismatch($sformatf("led_valid %0b, expected %0b",
                                            rsp.led_valid, want.led_valid));
               if (rsp.last !== want.last)
                  report_mismatch($sformatf("last %0b, expected %0b", rsp.last, want.last));
            end
         end
         if (req.valid && req.ready)
            predict_ring(req.center_row, req.center_col, req.press_time, req.now_time,
                         req.is_command, req.note_unused, req.in_scale);
      end
      pending = ring_words_q.size();
   end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Testbench top for the hex ring LED animation: clock, reset, key and register stimulus, verdict.
module testbench;
   import hrla_pkg::*;

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [TIME_W-1:0] press;
      logic [TIME_W-1:0] now;
      logic              cmd;
      logic              unused;
      logic              in_scale;
   } key_word_type;

   localparam int NUM_PHASES     = 8;
   localparam int KEYS_PER_PHASE = 50;
   localparam int DRAIN_PAD      = 24;
   localparam int HOLD_OFF       = 400;
   localparam int LIMIT          = 2_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hrla_req_if req_if ();
   hrla_rsp_if rsp_if ();
   hrla_csr_if csr_if ();

   int failures;
   int pending;
   int checked;
   int keys_sent;
   int cycles;

   mode_type         mode_now;
   logic [FPS_W-1:0] fps_now;
   bit               idle_en;
   int               tx_idle_pct;
   int               rx_idle_pct;
   bit               hold_request;

   mode_type         phase_mode [NUM_PHASES] = '{MODE_STAR, MODE_SPLASH, MODE_STAR_REV,
                                                 MODE_SPLASH_REV, MODE_SPLASH, MODE_SPLASH,
                                                 MODE_STAR, MODE_SPLASH_REV};
   logic [FPS_W-1:0] phase_fps  [NUM_PHASES] = '{8'd255, 8'd30, 8'd0, 8'd128, 8'd0, 8'd7,
                                                 8'd1, 8'd255};
   logic             phase_lock [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                                                 1'b1, 1'b0};

   always #5 clock = ~clock;

   hex_ring_led_animation u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   led_ring_checker u_checker (
      .clock    (clock),
      .reset    (reset),
      .req      (req_if),
      .rsp      (rsp_if),
      .csr      (csr_if),
      .failures (failures),
      .pending  (pending),
      .checked  (checked)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("Timeout after %0d cycles with %0d LED words outstanding", cycles, pending);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // elapsed time that lands near the given frame at the given rate, or a random time at rate zero
   function automatic logic [TIME_W-1:0] delay_for_frame(input int f, input logic [FPS_W-1:0] fps);
      logic [TIME_W-1:0] spread;
      if (fps == '0) return {$urandom, $urandom};
      spread = (TIME_W'(f - 1) << FRAME_SHIFT)
             + TIME_W'($urandom_range(0, (1 << FRAME_SHIFT) - 1));
      return spread / TIME_W'(fps);
   endfunction

   function automatic key_word_type make_key(input logic [ROW_W-1:0] row,
                                             input logic [COL_W-1:0] col,
                                             input logic [TIME_W-1:0] press,
                                             input logic [TIME_W-1:0] now,
                                             input logic cmd, input logic unused,
                                             input logic in_scale);
      key_word_type k;
      k.row      = row;
      k.col      = col;
      k.press    = press;
      k.now      = now;
      k.cmd      = cmd;
      k.unused   = unused;
      k.in_scale = in_scale;
      return k;
   endfunction

   function automatic key_word_type random_key();
      key_word_type k;
      int           kind;
      int           top_frame;
      kind    = $urandom_range(0, 99);
      k.press = {$urandom, $urandom};
      if (kind < 80) begin
         top_frame = (mode_now == MODE_STAR || mode_now == MODE_SPLASH) ? ROWS : REVERSE_RADIUS;
         k.row = ROW_W'($urandom_range(0, ROWS - 1));
         k.col = COL_W'(2 * $urandom_range(0, COLS - 1)) + COL_W'(k.row[0]);
         if (k.press == '0) k.press = 1;
         k.now      = k.press + delay_for_frame($urandom_range(1, top_frame), fps_now);
         k.cmd      = 1'b0;
         k.unused   = 1'b0;
         k.in_scale = ($urandom_range(0, 7) != 0);
      end else begin
         k.row = ROW_W'($urandom);
         k.col = COL_W'($urandom);
         k.now = {$urandom, $urandom};
         if (kind < 85) k.press = '0;
         {k.cmd, k.unused, k.in_scale} = 3'($urandom);
      end
      return k;
   endfunction

   task automatic send_key(input key_word_type k);
      if (idle_en && $urandom_range(0, 99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.center_row  <= k.row;
      req_if.center_col  <= k.col;
      req_if.press_time  <= k.press;
      req_if.now_time    <= k.now;
      req_if.is_command  <= k.cmd;
      req_if.note_unused <= k.unused;
      req_if.in_scale    <= k.in_scale;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      keys_sent++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
   endtask

   task automatic configure(input mode_type m, input logic [FPS_W-1:0] fps, input logic lock);
      write_reg(CSR_MODE, CSR_DATA_W'(m));
      write_reg(CSR_FPS, CSR_DATA_W'(fps));
      write_reg(CSR_SCALE_LOCK, CSR_DATA_W'(lock));
      csr_if.valid <= 1'b0;
      mode_now = m;
      fps_now  = fps;
   endtask

   // stop offering keys until every predicted word is back and the pipe is quiet
   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
            hold_request = 1'b0;
         end else if (idle_en && $urandom_range(0, 99) < rx_idle_pct) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(0, 15)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      req_if.valid       <= 1'b0;
      req_if.center_row  <= '0;
      req_if.center_col  <= '0;
      req_if.press_time  <= '0;
      req_if.now_time    <= '0;
      req_if.is_command  <= 1'b0;
      req_if.note_unused <= 1'b0;
      req_if.in_scale    <= 1'b0;
      csr_if.valid       <= 1'b0;
      csr_if.index       <= CSR_MODE;
      csr_if.data        <= '0;
      mode_now     = MODE_STAR;
      fps_now      = FPS_W'(FPS_RESET);
      idle_en      = 1'b1;
      tx_idle_pct  = 20;
      rx_idle_pct  = 20;
      hold_request = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: star, 30 fps, no scale lock
      send_key(make_key(4'd4, 5'd8, 64'd1000, 64'd1000, 1'b0, 1'b0, 1'b1));
      send_key(make_key(4'd0, 5'd0, 64'd5, 64'd5 + delay_for_frame(3, fps_now), 1'b0, 1'b0, 1'b1));
      send_key(make_key(4'd9, 5'd19, 64'd77, 64'd77 + delay_for_frame(9, fps_now),
                        1'b0, 1'b0, 1'b1));
      send_key(make_key(4'd9, 5'd1, 64'd9, 64'd9 + delay_for_frame(5, fps_now), 1'b0, 1'b0, 1'b1));
      send_key(make_key(4'd5, 5'd5, 64'd3, 64'd3 + delay_for_frame(10, fps_now),
                        1'b0, 1'b0, 1'b1));
      send_key(make_key(4'd4, 5'd8, 64'd0, 64'd12, 1'b0, 1'b0, 1'b1));
      send_key(make_key(4'd4, 5'd8, 64'd40, 64'd40, 1'b1, 1'b0, 1'b1));
      send_key(make_key(4'd4, 5'd8, 64'd40, 64'd40, 1'b0, 1'b1, 1'b1));
      send_key(make_key(4'd15, 5'd31, 64'd8, 64'd8 + delay_for_frame(2, fps_now),
                        1'b0, 1'b0, 1'b1));
      send_key(make_key(4'd0, 5'd1, 64'd8, 64'd8 + delay_for_frame(3, fps_now), 1'b0, 1'b0, 1'b1));
      send_key(make_key(4'd3, 5'd7, '1, 64'd3, 1'b0, 1'b0, 1'b1));
      send_key(make_key(4'd6, 5'd10, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                        1'b0, 1'b0, 1'b1));
      send_key(make_key(4'd2, 5'd12, 64'd50, 64'd50 + delay_for_frame(4, fps_now),
                        1'b0, 1'b0, 1'b0));
      send_key(make_key(4'd7, 5'd3, 64'd1, '1, 1'b0, 1'b0, 1'b1));
      send_key(make_key(4'd5, 5'd9, 64'd2, 64'd2 + delay_for_frame(8, fps_now), 1'b0, 1'b0, 1'b1));

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         configure(phase_mode[p], phase_fps[p], phase_lock[p]);
         idle_en     = (p != NUM_PHASES - 1);
         tx_idle_pct = $urandom_range(0, 40);
         rx_idle_pct = $urandom_range(0, 40);
         if (p == 5) hold_request = 1'b1;
         for (int i = 0; i < KEYS_PER_PHASE; i++) begin
            if (p == 2 && i == KEYS_PER_PHASE / 2) drain();
            send_key(random_key());
         end
      end
      drain();

      $display("Sent %0d key words under %0d register settings, %0d LED words compared.",
               keys_sent, NUM_PHASES + 1, checked);
      $display("Star, splash and both reverse modes, 0 to 255 fps, scale lock, long output stall.");
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", failures);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/hrla_pkg.sv
hw/rtl/hrla_req_if.sv
hw/rtl/hrla_rsp_if.sv
hw/rtl/hrla_csr_if.sv
hw/rtl/hrla_frame_unit.sv
hw/rtl/hrla_ring_walker.sv
hw/rtl/hex_ring_led_animation.sv
hw/rtl/hrla_checker.sv
tb/led_ring_checker.sv
tb/testbench.sv
